/* hw/rtl/csvlt_pkg.sv */
// ----------------------------------------------------------------------------
// csvlt_pkg: shared types and constants of the CSV line tokenizer
// Character codes, result kinds and the command passed from the classifier
// to the result sequencer.
// ----------------------------------------------------------------------------
package csvlt_pkg;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam logic [7:0] SEP_RESET = 8'h2C;

	// Depth of the command queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_FIELD = 2'd1,
		KIND_LINE  = 2'd2
	} kind_t;

	// One classified item: first result, plus a trailing line end if set
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       add_line;
	} cmd_t;

endpackage

/* hw/rtl/csvlt_front.sv */
// ----------------------------------------------------------------------------
// csvlt_front: input classifier
// Accepts input bytes, tracks quote and field state, and turns each byte into
// at most one command for the result sequencer.
// ----------------------------------------------------------------------------
module csvlt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [7:0]        cfg_wdata,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // in_byte
	input  logic              s_tuser,   // end_of_input
	input  logic              q_full,
	output logic              q_push,
	output csvlt_pkg::cmd_t   q_cmd
);

	logic [7:0] sep_q;
	logic       in_quotes_q;
	logic       quote_pending_q;
	logic       field_nonempty_q;

	logic       in_quotes_d;
	logic       quote_pending_d;
	logic       field_nonempty_d;
	logic       emit;
	logic       iq;
	logic       accept;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign q_push   = accept && emit;

	// Classify the byte against the current quote state
	always_comb begin
		in_quotes_d      = in_quotes_q;
		quote_pending_d  = 1'b0;
		field_nonempty_d = field_nonempty_q;
		emit             = 1'b0;
		q_cmd.kind       = csvlt_pkg::KIND_DATA;
		q_cmd.data       = 8'd0;
		q_cmd.add_line   = 1'b0;
		iq               = in_quotes_q && !quote_pending_q;
		if (quote_pending_q && !s_tuser && s_tdata == csvlt_pkg::CH_QUOTE) begin
			// doubled quote inside quotes: literal quote
			emit             = 1'b1;
			q_cmd.data       = csvlt_pkg::CH_QUOTE;
			field_nonempty_d = 1'b1;
		end else begin
			in_quotes_d = iq;
			if (s_tuser || (s_tdata == csvlt_pkg::CH_LF && !iq)) begin
				// close the line, ending a nonempty field first
				emit             = 1'b1;
				q_cmd.kind       = field_nonempty_q ? csvlt_pkg::KIND_FIELD
				                                    : csvlt_pkg::KIND_LINE;
				q_cmd.add_line   = field_nonempty_q;
				in_quotes_d      = 1'b0;
				field_nonempty_d = 1'b0;
			end else if (s_tdata == csvlt_pkg::CH_LF) begin
				emit             = 1'b1;
				q_cmd.data       = s_tdata;
				field_nonempty_d = 1'b1;
			end else if (s_tdata == sep_q && !iq) begin
				emit             = 1'b1;
				q_cmd.kind       = csvlt_pkg::KIND_FIELD;
				field_nonempty_d = 1'b0;
			end else if (s_tdata == csvlt_pkg::CH_QUOTE) begin
				if (iq) begin
					quote_pending_d = 1'b1;
				end else begin
					in_quotes_d = 1'b1;
				end
			end else if (s_tdata != csvlt_pkg::CH_CR) begin
				emit             = 1'b1;
				q_cmd.data       = s_tdata;
				field_nonempty_d = 1'b1;
			end
		end
	end

	// Hold the separator register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= csvlt_pkg::SEP_RESET;
		end else if (cfg_wen) begin
			sep_q <= cfg_wdata;
		end
	end

	// Advance parser state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quotes_q      <= 1'b0;
			quote_pending_q  <= 1'b0;
			field_nonempty_q <= 1'b0;
		end else if (accept) begin
			in_quotes_q      <= in_quotes_d;
			quote_pending_q  <= quote_pending_d;
			field_nonempty_q <= field_nonempty_d;
		end
	end

endmodule

/* hw/rtl/csvlt_queue.sv */
// ----------------------------------------------------------------------------
// csvlt_queue: command queue
// Small register queue that decouples the classifier from the sequencer.
// ----------------------------------------------------------------------------
module csvlt_queue #(
	parameter int unsigned DEPTH = csvlt_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  csvlt_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            nonempty,
	output csvlt_pkg::cmd_t head
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	csvlt_pkg::cmd_t entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = entry_q[rd_ptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/csvlt_back.sv */
// ----------------------------------------------------------------------------
// csvlt_back: result sequencer
// Pops commands and drives the output register, one result per cycle while
// m_tready is high, splitting a field end plus line end into two transactions.
// ----------------------------------------------------------------------------
module csvlt_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_nonempty,
	input  csvlt_pkg::cmd_t q_head,
	output logic            q_pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,   // out_byte
	output logic [1:0]      m_tuser,   // out_kind
	output logic            m_tlast    // last_of_run
);

	logic             valid_q;
	csvlt_pkg::kind_t kind_q;
	logic [7:0]       data_q;
	logic             last_q;
	logic             line_pending_q;
	logic             load;

	assign load  = !valid_q || m_tready;
	assign q_pop = load && !line_pending_q && q_nonempty;

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	// Control: output valid and the trailing line end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= 1'b0;
			line_pending_q <= 1'b0;
		end else if (load) begin
			if (line_pending_q) begin
				valid_q        <= 1'b1;
				line_pending_q <= 1'b0;
			end else begin
				valid_q        <= q_nonempty;
				line_pending_q <= q_nonempty && q_head.add_line;
			end
		end
	end

	// Payload of the output register
	always_ff @(posedge clk) begin
		if (load) begin
			if (line_pending_q) begin
				kind_q <= csvlt_pkg::KIND_LINE;
				data_q <= 8'd0;
				last_q <= 1'b1;
			end else begin
				kind_q <= q_head.kind;
				data_q <= q_head.data;
				last_q <= !q_head.add_line;
			end
		end
	end

endmodule

/* hw/rtl/csv_line_tokenizer.sv */
// Path: each result is registered in the command queue and then in the output
// register that drives m_*. Throughput: one input byte per cycle unless the
// queue is full; one result per cycle unless m_tready is low, so a byte that
// closes a nonempty field and its line takes two output transactions.
// The command queue (2 entries) lets input continue while output stalls.
// Reset: arst_n clears quote/field state, queue and output; separator is ','.
// ----------------------------------------------------------------------------
// csv_line_tokenizer: CSV field and line splitter
// Streams field data bytes, field ends and line ends from a byte stream.
// ----------------------------------------------------------------------------
module csv_line_tokenizer #(
	parameter int unsigned QUEUE_DEPTH = csvlt_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic [7:0] cfg_wdata,  // separator_char
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // [7:0] in_byte
	input  logic       s_tuser,    // [0] end_of_input
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // [7:0] out_byte
	output logic [1:0] m_tuser,    // [1:0] out_kind
	output logic       m_tlast     // last_of_run
);

	logic            q_full;
	logic            q_push;
	logic            q_pop;
	logic            q_nonempty;
	csvlt_pkg::cmd_t push_cmd;
	csvlt_pkg::cmd_t head_cmd;

	csvlt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (push_cmd)
	);

	csvlt_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.head     (head_cmd)
	);

	csvlt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (head_cmd),
		.q_pop      (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

/* hw/rtl/csvlt_checker.sv */
// ----------------------------------------------------------------------------
// csvlt_checker: port-level checks of the CSV line tokenizer
// Watches the output stream for stall hold, ordering and encoding rules.
// ----------------------------------------------------------------------------
module csvlt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [1:0] m_tuser,
	input logic       m_tlast
);

	// Hold a stalled transaction unchanged
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("output changed while stalled");

	// A field end that is not last must be followed at once by a line end
	a_field_then_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser == csvlt_pkg::KIND_FIELD && !m_tlast
		|=> m_tvalid && m_tuser == csvlt_pkg::KIND_LINE && m_tlast)
		else $error("field end without following line end");

	// Data bytes and line ends always finish their input item
	a_last_rule: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == csvlt_pkg::KIND_DATA || m_tuser == csvlt_pkg::KIND_LINE)
		|-> m_tlast)
		else $error("data or line result not marked last");

	// Non-data results carry a zero byte and a valid kind
	a_kind_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != csvlt_pkg::KIND_DATA
		|-> m_tdata == 8'd0 && m_tuser != 2'd3)
		else $error("bad kind or nonzero byte on control result");

endmodule

bind csv_line_tokenizer csvlt_checker u_csvlt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
